FILE: sv/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int OpW  = 16;
    localparam int ResW = 33;
    localparam int ReqW = 3;

    typedef enum logic [ReqW-1:0] {
        REQ_ADD = 3'd0,
        REQ_SUB = 3'd1,
        REQ_MUL = 3'd2,
        REQ_DIV = 3'd3,
        REQ_SMP = 3'd4
    } req_type_t;

    typedef struct packed {
        logic [ReqW-1:0]  req_type;
        logic signed [OpW-1:0] a_num;
        logic signed [OpW-1:0] a_den;
        logic signed [OpW-1:0] b_num;
        logic signed [OpW-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [ResW-1:0] res_num;
        logic signed [ResW-1:0] res_den;
        logic                   gcd_zero_error;
    } res_t;

    localparam int InBytes  = (ReqW + 4*OpW + 7) / 8;
    localparam int OutBytes = (2*ResW + 1 + 7) / 8;

endpackage

FILE: sv/rau_front.sv
// ---------------------------------------------------------------------------
// rau_front
// Input stage and two-entry word queue in front of the execution unit.
// ---------------------------------------------------------------------------
module rau_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rau_pkg::req_t                   in_req,
    output logic                            q_valid,
    input  logic                            q_ready,
    output rau_pkg::req_t                   q_req
);
    import rau_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: sv/rau_back.sv
// ---------------------------------------------------------------------------
// rau_back
// Execution unit: cross products on one multiplier, Euclid and quotients on
// a shared restoring divider, result register toward the output.
// ---------------------------------------------------------------------------
module rau_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  rau_pkg::req_t  q_req,
    output logic           out_valid,
    input  logic           out_ready,
    output rau_pkg::res_t  out_res
);
    import rau_pkg::*;

    localparam int CntW = $clog2(OpW + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_GCD  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_QN   = 7'b0010000,
        ST_QD   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                 state_reg;
    req_t                   req_reg;
    logic [1:0]             step_reg;
    logic signed [2*OpW:0]  p_reg [3];
    logic [OpW:0]           x_reg, y_reg;
    logic [OpW:0]           dd_reg, quo_reg;
    logic [OpW:0]           rem_reg;
    logic [CntW-1:0]        cnt_reg;
    logic                   neg_reg;
    logic                   gneg_reg;
    logic                   par_reg;
    res_t                   res_reg;

    logic signed [OpW-1:0]  ma, mb;
    logic signed [2*OpW:0]  prod;
    logic [OpW+1:0]         trial;
    logic [OpW:0]           rem_sh;
    logic [OpW:0]           abs_an, abs_ad;
    logic [OpW:0]           quo_fin;
    logic                   gneg;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                ma = req_reg.a_num;
                mb = (req_reg.req_type == REQ_MUL) ? req_reg.b_num : req_reg.b_den;
            end
            2'd1:
            begin
                ma = req_reg.a_den;
                mb = req_reg.b_num;
            end
            default:
            begin
                ma = req_reg.a_den;
                mb = req_reg.b_den;
            end
        endcase
    end
    assign prod = (2*OpW+1)'(ma * mb);

    assign abs_an = req_reg.a_num[OpW-1] ? (OpW+1)'(-{req_reg.a_num[OpW-1], req_reg.a_num})
                                         : {1'b0, req_reg.a_num};
    assign abs_ad = req_reg.a_den[OpW-1] ? (OpW+1)'(-{req_reg.a_den[OpW-1], req_reg.a_den})
                                         : {1'b0, req_reg.a_den};

    assign rem_sh  = {rem_reg[OpW-1:0], dd_reg[OpW]};
    assign trial   = {1'b0, rem_sh} - {1'b0, y_reg};
    assign quo_fin = {quo_reg[OpW-1:0], !trial[OpW+1]};

    // g ends on an even step with the sign of a_num, on an odd one with a_den's
    assign gneg = par_reg ? req_reg.a_den[OpW-1] : req_reg.a_num[OpW-1];

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= (q_req.req_type == REQ_SMP) ? ST_GCD : ST_MUL;
                        step_reg  <= 2'd0;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_GCD:
                begin
                    cnt_reg <= '0;
                    if (y_reg == '0)
                    begin
                        state_reg <= (x_reg == '0) ? ST_OUT : ST_QN;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV, ST_QN, ST_QD:
                begin
                    if (cnt_reg == CntW'(OpW))
                    begin
                        cnt_reg <= '0;
                        case (state_reg)
                            ST_DIV:  state_reg <= ST_GCD;
                            ST_QN:   state_reg <= ST_QD;
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CntW'(1);
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath; gcd runs on magnitudes, sign of g follows truncated remainders
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                req_reg <= q_req;
                x_reg   <= q_req.a_num[OpW-1] ? (OpW+1)'(-{q_req.a_num[OpW-1], q_req.a_num})
                                              : {1'b0, q_req.a_num};
                y_reg   <= q_req.a_den[OpW-1] ? (OpW+1)'(-{q_req.a_den[OpW-1], q_req.a_den})
                                              : {1'b0, q_req.a_den};
                par_reg <= 1'b0;
                res_reg.res_num <= ResW'(q_req.a_num);
                res_reg.res_den <= ResW'(q_req.a_den);
                res_reg.gcd_zero_error <= 1'b0;
            end
            ST_MUL:
            begin
                p_reg[step_reg] <= prod;
                if (step_reg == 2'd2)
                begin
                    case (req_reg.req_type)
                        REQ_ADD:
                        begin
                            res_reg.res_num <= ResW'(p_reg[0] + p_reg[1]);
                            res_reg.res_den <= ResW'(prod);
                        end
                        REQ_SUB:
                        begin
                            res_reg.res_num <= ResW'(p_reg[0] - p_reg[1]);
                            res_reg.res_den <= ResW'(prod);
                        end
                        REQ_MUL:
                        begin
                            res_reg.res_num <= ResW'(p_reg[0]);
                            res_reg.res_den <= ResW'(prod);
                        end
                        REQ_DIV:
                        begin
                            res_reg.res_num <= ResW'(p_reg[0]);
                            res_reg.res_den <= ResW'(p_reg[1]);
                        end
                        default: ;
                    endcase
                end
            end
            ST_GCD:
            begin
                rem_reg <= '0;
                quo_reg <= '0;
                if (y_reg == '0)
                begin
                    if (x_reg == '0)
                    begin
                        res_reg.gcd_zero_error <= 1'b1;
                    end
                    else
                    begin
                        gneg_reg <= gneg;
                        y_reg    <= x_reg;
                        dd_reg   <= abs_an;
                        neg_reg  <= req_reg.a_num[OpW-1] ^ gneg;
                    end
                end
                else
                begin
                    dd_reg <= x_reg;
                end
            end
            ST_DIV, ST_QN, ST_QD:
            begin
                if (cnt_reg == CntW'(OpW))
                begin
                    case (state_reg)
                        ST_DIV:
                        begin
                            x_reg   <= y_reg;
                            y_reg   <= trial[OpW+1] ? rem_sh : trial[OpW:0];
                            par_reg <= ~par_reg;
                        end
                        ST_QN:
                        begin
                            res_reg.res_num <= neg_reg ? -ResW'(quo_fin) : ResW'(quo_fin);
                            dd_reg  <= abs_ad;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            neg_reg <= req_reg.a_den[OpW-1] ^ gneg_reg;
                        end
                        default:
                        begin
                            res_reg.res_den <= neg_reg ? -ResW'(quo_fin) : ResW'(quo_fin);
                        end
                    endcase
                end
                else
                begin
                    if (!trial[OpW+1])
                    begin
                        rem_reg <= trial[OpW:0];
                        quo_reg <= {quo_reg[OpW-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[OpW-1:0], 1'b0};
                    end
                    dd_reg <= {dd_reg[OpW-1:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/rational_arithmetic_unit_top.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Rational add, subtract, multiply, divide and simplify by Euclid's gcd.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word; m_axis returns one result word per
//   request, in order. A two-word queue holds requests while the execution
//   unit works, so the input side keeps taking words during a busy item.
//   Arithmetic ops form three products on one 16x16 multiplier, then the
//   result word. Simplify runs the restoring divider once per Euclid
//   remainder step and twice more for the two quotients; a 0/0 operand
//   returns with gcd_zero_error set and no division. One item runs at a
//   time: a new request is taken only once the last result is accepted.
//   Reset clears the queue and returns the unit to idle. While m_axis_tready
//   is low the result holds and the unit takes no new item; the queue fills
//   and then s_axis_tready drops.
//   The sign of g follows the truncated remainders, so reduced parts carry
//   the signs of C division.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // req_type, a_num, a_den, b_num, b_den
    input  logic [rau_pkg::InBytes*8-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // res_num, res_den, gcd_zero_error
    output logic [rau_pkg::OutBytes*8-1:0]     m_axis_tdata
);
    import rau_pkg::*;

    req_t in_req, q_req;
    res_t res;
    logic q_valid, q_ready;

    assign in_req.req_type = s_axis_tdata[ReqW-1:0];
    assign in_req.a_num    = s_axis_tdata[ReqW+OpW-1:ReqW];
    assign in_req.a_den    = s_axis_tdata[ReqW+2*OpW-1:ReqW+OpW];
    assign in_req.b_num    = s_axis_tdata[ReqW+3*OpW-1:ReqW+2*OpW];
    assign in_req.b_den    = s_axis_tdata[ReqW+4*OpW-1:ReqW+3*OpW];

    rau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {(OutBytes*8-2*ResW-1)'(0), res.gcd_zero_error,
                           res.res_den, res.res_num};

endmodule

FILE: sv/rau_checker.sv
// ---------------------------------------------------------------------------
// rau_props
// Port-level checks of the rational arithmetic unit.
// ---------------------------------------------------------------------------
module rau_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid && s_axis_tready)
        else $error("result valid or input blocked during reset");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:67] == 5'd0)
        else $error("pad bits set");

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("back-to-back result without request");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(s_axis_tready) && !$isunknown(s_axis_tvalid))
        else $error("input handshake unknown");
endmodule

bind rational_arithmetic_unit_top rau_props u_rau_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/rau_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_checker
// Watches both stream channels of the rational arithmetic unit, predicts the
// result word for every accepted request word and compares it field by field
// with the words that come out, in order.
// ---------------------------------------------------------------------------
module rau_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [rau_pkg::InBytes*8-1:0]      s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [rau_pkg::OutBytes*8-1:0]     m_axis_tdata,
    output int                                 mismatches,
    output int                                 outstanding
);
    import rau_pkg::*;

    res_t result_fifo[$];

    // remainders truncate toward zero, so the sign of the gcd follows C
    function automatic longint euclid_gcd(longint x, longint y);
        longint t;
        while (y != 0)
        begin
            t = y;
            y = x % y;
            x = t;
        end
        return x;
    endfunction

    function automatic res_t rational_result(logic [InBytes*8-1:0] w);
        res_t   r;
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint rn;
        longint rd;
        longint g;
        an = longint'($signed(w[18:3]));
        ad = longint'($signed(w[34:19]));
        bn = longint'($signed(w[50:35]));
        bd = longint'($signed(w[66:51]));
        rn = an;
        rd = ad;
        r.gcd_zero_error = 1'b0;
        case (w[2:0])
            REQ_ADD:
            begin
                rn = an * bd + ad * bn;
                rd = ad * bd;
            end
            REQ_SUB:
            begin
                rn = an * bd - ad * bn;
                rd = ad * bd;
            end
            REQ_MUL:
            begin
                rn = an * bn;
                rd = ad * bd;
            end
            REQ_DIV:
            begin
                rn = an * bd;
                rd = bn * ad;
            end
            REQ_SMP:
            begin
                g = euclid_gcd(an, ad);
                if (g == 0)
                begin
                    r.gcd_zero_error = 1'b1;
                end
                else
                begin
                    rn = an / g;
                    rd = ad / g;
                end
            end
            default:
            begin
            end
        endcase
        r.res_num = rn[ResW-1:0];
        r.res_den = rd[ResW-1:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("rau_checker: %s mismatch at %0t: got %0h expected %0h",
                 what, $realtime, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        res_t want;
        logic [ResW-1:0] got_num;
        logic [ResW-1:0] got_den;
        logic            got_err;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                result_fifo.push_back(rational_result(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_num = m_axis_tdata[32:0];
                got_den = m_axis_tdata[65:33];
                got_err = m_axis_tdata[66];
                if (result_fifo.size() == 0)
                begin
                    report("unexpected word", longint'(m_axis_tdata[66:0]), 0);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got_num !== want.res_num)
                        report("res_num", longint'(got_num), longint'(want.res_num));
                    if (got_den !== want.res_den)
                        report("res_den", longint'(got_den), longint'(want.res_den));
                    if (got_err !== want.gcd_zero_error)
                        report("gcd_zero_error", longint'(got_err),
                               longint'(want.gcd_zero_error));
                end
            end
        end
        outstanding = result_fifo.size();
    end

endmodule

FILE: test/tb_rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rational_arithmetic_unit_top
// Drives request words into the rational arithmetic unit: a directed set of
// extremes and corner cases, then random bursts with gaps, while the result
// side stalls at random. A checker module predicts and compares.
// ---------------------------------------------------------------------------
module tb_rational_arithmetic_unit_top;
    import rau_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [InBytes*8-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OutBytes*8-1:0]  m_axis_tdata;
    int                     mismatches;
    int                     outstanding;
    logic                   long_hold;
    logic                   hold_done;

    rational_arithmetic_unit_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rau_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("tb_rational_arithmetic_unit_top: errors");
        $finish;
    end

    // stall pattern of the result side, plus one long hold-off on request
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        mode          = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_word(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
                             logic [15:0] bn, logic [15:0] bd, bit keep_valid);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, bd, bn, ad, an, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!keep_valid)
            s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'(int'($urandom_range(0, 16)) - 8);
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [2:0]  op;
        logic [15:0] an;
        logic [15:0] ad;
        logic [15:0] bn;
        logic [15:0] bd;
        int          k;
        int          burst;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        long_hold     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(REQ_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_word(REQ_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_word(REQ_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0);
        send_word(REQ_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
        send_word(REQ_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_word(REQ_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 1'b0);
        send_word(REQ_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_word(REQ_DIV, 16'd3, 16'd4, 16'd0, 16'd5, 1'b0);
        send_word(REQ_ADD, 16'd1, 16'd0, 16'd1, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'd0, 16'd0, 16'h1234, 16'h5678, 1'b0);
        send_word(REQ_SMP, 16'd7, 16'd0, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'hfff9, 16'd0, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'd0, 16'd9, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'd0, 16'hfff7, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'h8000, 16'h8000, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'h8000, 16'hffff, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'hffc4, 16'd48, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'd60, 16'hffd0, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'hfffa, 16'd4, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'hfffa, 16'hfffc, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'h7fff, 16'h7ffe, 16'd0, 16'd0, 1'b0);
        send_word(REQ_SMP, 16'd17711, 16'd28657, 16'd0, 16'd0, 1'b0);
        send_word(3'd5, 16'h8000, 16'h7fff, 16'h1111, 16'h2222, 1'b0);
        send_word(3'd6, 16'h7fff, 16'h8000, 16'h3333, 16'h4444, 1'b0);
        send_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);

        k = 0;
        while (k < 1800)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && k < 1800)
            begin
                op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
                an = pick_value();
                ad = pick_value();
                bn = pick_value();
                bd = pick_value();
                if (op == REQ_SMP && $urandom_range(0, 1) == 1)
                begin
                    // built from products of small factors so the reduction often does real work
                    an = 16'(($signed(16'(int'($urandom_range(0, 60)) - 30)))
                             * int'($urandom_range(1, 500)));
                    ad = 16'(int'($urandom_range(1, 60)) * int'(an[3:0] + 1)
                             * (($urandom_range(0, 1) == 1) ? -1 : 1));
                end
                if (k == 400)
                    long_hold = 1'b1;
                send_word(op, an, ad, bn, bd, burst > 1 && k != 899);
                burst--;
                k++;
                if (k == 900)
                begin
                    @(posedge clk);
                    while (outstanding != 0)
                        @(posedge clk);
                end
            end
            if (s_axis_tvalid === 1'b1 || $urandom_range(0, 1) == 1)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0)
            $display("tb_rational_arithmetic_unit_top: clean");
        else
            $display("tb_rational_arithmetic_unit_top: errors");
        $finish;
    end

endmodule
